// ===== design/assert_macros.svh =====
// assertion macros shared by the lexer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CLX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold outside reset
`define CLX_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== design/clx_pkg.sv =====
// package: token kinds, lexer modes, result records and classification helpers
package clx_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int RES_MAX = 3;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  localparam logic [4:0] K_ID     = 5'd0;
  localparam logic [4:0] K_NUM    = 5'd1;
  localparam logic [4:0] K_INT    = 5'd2;
  localparam logic [4:0] K_FLOAT  = 5'd3;
  localparam logic [4:0] K_IF     = 5'd4;
  localparam logic [4:0] K_ELSE   = 5'd5;
  localparam logic [4:0] K_RETURN = 5'd6;
  localparam logic [4:0] K_PLUS   = 5'd7;
  localparam logic [4:0] K_MINUS  = 5'd8;
  localparam logic [4:0] K_STAR   = 5'd9;
  localparam logic [4:0] K_SLASH  = 5'd10;
  localparam logic [4:0] K_ASSIGN = 5'd11;
  localparam logic [4:0] K_EQ     = 5'd12;
  localparam logic [4:0] K_LT     = 5'd13;
  localparam logic [4:0] K_LE     = 5'd14;
  localparam logic [4:0] K_GT     = 5'd15;
  localparam logic [4:0] K_LPAREN = 5'd16;
  localparam logic [4:0] K_RPAREN = 5'd17;
  localparam logic [4:0] K_LBRACE = 5'd18;
  localparam logic [4:0] K_RBRACE = 5'd19;
  localparam logic [4:0] K_SEMI   = 5'd20;
  localparam logic [4:0] K_END    = 5'd21;
  localparam logic [4:0] K_BAD    = 5'd22;

  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // keyword spellings, last byte lowest
  localparam logic [47:0] KW_INT    = 48'h0000_0069_6E74;
  localparam logic [47:0] KW_FLOAT  = 48'h0066_6C6F_6174;
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [47:0] KW_ELSE   = 48'h0000_656C_7365;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NUM  = 3'd1,
    MODE_WORD = 3'd2,
    MODE_PEQ  = 3'd3,
    MODE_PLT  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic [7:0]  bad_byte;
  } result_t;

  // all tokens caused by one source byte
  typedef struct packed {
    logic [1:0]          count;
    result_t [RES_MAX-1:0] slot;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [4:0] word_kind(input logic [15:0] len, input logic [47:0] chars);
    logic [4:0] k;
    k = K_ID;
    if (len == 16'd3 && chars == KW_INT) k = K_INT;
    if (len == 16'd5 && chars == KW_FLOAT) k = K_FLOAT;
    if (len == 16'd2 && chars == KW_IF) k = K_IF;
    if (len == 16'd4 && chars == KW_ELSE) k = K_ELSE;
    if (len == 16'd6 && chars == KW_RETURN) k = K_RETURN;
    return k;
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_STAR;
      8'h2F:   k = K_SLASH;
      CH_GT:   k = K_GT;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      CH_SEMI: k = K_SEMI;
      default: k = K_BAD;
    endcase
    return k;
  endfunction

  function automatic result_t make_res(input logic [4:0] kind,
                                       input logic [OFFSET_BITS-1:0] start,
                                       input logic [15:0] len,
                                       input logic [7:0] bad);
    result_t r;
    r.kind = kind;
    r.start_res = 16'(start);
    r.length = len;
    r.bad_byte = bad;
    return r;
  endfunction

endpackage

// ===== design/clx_ifs.sv =====
// request channel interfaces: source bytes in, tokens out
interface clx_byte_if import clx_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       final_byte;

  modport source(output valid, ch, final_byte, input ready);
  modport sink(input valid, ch, final_byte, output ready);
endinterface

interface clx_tok_if import clx_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [15:0] start_res;
  logic [15:0] length;
  logic [7:0]  bad_byte;
  logic        run_end;

  modport source(output valid, kind, start_res, length, bad_byte, run_end, input ready);
  modport sink(input valid, kind, start_res, length, bad_byte, run_end, output ready);
endinterface

// ===== design/clx_front.sv =====
// front end: accepts bytes, tracks the open token and builds token bundles
module clx_front import clx_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  clx_byte_if.sink       bytes,
  input  logic           q_full,
  output logic           push,
  output bundle_t        bundle
);

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] offset, offset_next;
  logic [OFFSET_BITS-1:0] token_start, token_start_next;
  logic [15:0]            token_len, token_len_next;
  logic [47:0]            keyword_chars, keyword_chars_next;
  logic                   accept;

  assign bytes.ready = !q_full;
  assign accept = bytes.valid && bytes.ready;

  always_comb begin
    logic [7:0]             c;
    logic                   used;
    logic [1:0]             n;
    logic [OFFSET_BITS-1:0] pos;
    mode_t                  m1;
    logic [OFFSET_BITS-1:0] s1;
    logic [15:0]            l1;
    logic [47:0]            k1;
    c = bytes.ch;
    pos = offset;
    used = 1'b0;
    n = 2'd0;
    bundle.slot = '0;
    m1 = mode;
    s1 = token_start;
    l1 = token_len;
    k1 = keyword_chars;

    // close or extend the token left open by earlier bytes
    unique case (mode)
      MODE_PEQ, MODE_PLT: begin
        if (c == CH_EQ) begin
          bundle.slot[n] = make_res((mode == MODE_PEQ) ? K_EQ : K_LE, token_start, 16'd2, 8'd0);
          used = 1'b1;
        end else begin
          bundle.slot[n] = make_res((mode == MODE_PEQ) ? K_ASSIGN : K_LT, token_start, 16'd1,
                                    8'd0);
        end
        n = n + 2'd1;
        m1 = MODE_IDLE;
      end
      MODE_NUM, MODE_WORD: begin
        if (is_digit(c) || (mode == MODE_WORD && is_alpha(c))) begin
          l1 = (token_len == LEN_MAX) ? token_len : token_len + 16'd1;
          k1 = {keyword_chars[39:0], c};
          used = 1'b1;
        end else begin
          bundle.slot[n] = make_res((mode == MODE_NUM) ? K_NUM
                                    : word_kind(token_len, keyword_chars),
                                    token_start, token_len, 8'd0);
          n = n + 2'd1;
          m1 = MODE_IDLE;
        end
      end
      default: m1 = MODE_IDLE;
    endcase

    if (!used) begin
      priority if (is_space(c)) begin
        m1 = m1;
      end else if (is_digit(c) || is_alpha(c) || c == CH_EQ || c == CH_LT) begin
        priority if (is_digit(c)) m1 = MODE_NUM;
        else if (is_alpha(c)) m1 = MODE_WORD;
        else if (c == CH_EQ) m1 = MODE_PEQ;
        else m1 = MODE_PLT;
        s1 = pos;
        l1 = 16'd1;
        k1 = {40'd0, c};
      end else begin
        bundle.slot[n] = make_res(single_kind(c), pos, 16'd1,
                                  (single_kind(c) == K_BAD) ? c : 8'd0);
        n = n + 2'd1;
      end
    end

    offset_next = pos + 1'b1;
    mode_next = m1;
    token_start_next = s1;
    token_len_next = l1;
    keyword_chars_next = k1;

    // last byte: flush whatever is open, then the end marker, then back to reset
    if (bytes.final_byte) begin
      unique case (m1)
        MODE_NUM:  begin bundle.slot[n] = make_res(K_NUM, s1, l1, 8'd0); n = n + 2'd1; end
        MODE_WORD: begin
          bundle.slot[n] = make_res(word_kind(l1, k1), s1, l1, 8'd0);
          n = n + 2'd1;
        end
        MODE_PEQ:  begin bundle.slot[n] = make_res(K_ASSIGN, s1, 16'd1, 8'd0); n = n + 2'd1; end
        MODE_PLT:  begin bundle.slot[n] = make_res(K_LT, s1, 16'd1, 8'd0); n = n + 2'd1; end
        default:   n = n;
      endcase
      bundle.slot[n] = make_res(K_END, offset_next, 16'd0, 8'd0);
      n = n + 2'd1;
      offset_next = '0;
      mode_next = MODE_IDLE;
      token_start_next = '0;
      token_len_next = '0;
      keyword_chars_next = '0;
    end
    bundle.count = n;
  end

  assign push = accept && (bundle.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      offset <= '0;
      token_start <= '0;
      token_len <= '0;
      keyword_chars <= '0;
    end else if (accept) begin
      mode <= mode_next;
      offset <= offset_next;
      token_start <= token_start_next;
      token_len <= token_len_next;
      keyword_chars <= keyword_chars_next;
    end
  end

endmodule

// ===== design/clx_queue.sv =====
// two-entry bundle queue between front and back
`include "assert_macros.svh"
module clx_queue import clx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    empty,
  output bundle_t head
);

  bundle_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt, cnt_next;

  assign full = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign head = mem[rd_ptr];

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) cnt_next = cnt + 2'd1;
    if (pop && !push) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt_next;
    end
  end

  `CLX_NEVER(a_push_full, push && full, "bundle pushed into full queue")
  `CLX_NEVER(a_pop_empty, pop && empty, "bundle popped from empty queue")

endmodule

// ===== design/clx_back.sv =====
// back end: walks each bundle and drives one token per request
`include "assert_macros.svh"
module clx_back import clx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  bundle_t   head,
  output logic      pop,
  clx_tok_if.source tokens
);

  logic [1:0] sel, sel_next;
  logic       last;
  result_t    cur;

  assign cur = head.slot[sel];
  assign last = (sel == head.count - 2'd1);

  assign tokens.valid = !empty;
  assign tokens.kind = cur.kind;
  assign tokens.start_res = cur.start_res;
  assign tokens.length = cur.length;
  assign tokens.bad_byte = cur.bad_byte;
  assign tokens.run_end = last;

  assign pop = tokens.valid && tokens.ready && last;

  always_comb begin
    sel_next = sel;
    if (tokens.valid && tokens.ready) sel_next = last ? 2'd0 : sel + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) sel <= 2'd0;
    else sel <= sel_next;
  end

  `CLX_ASSERT(a_sel_range, (!empty) |-> (sel < head.count), "token index past bundle end")
  `CLX_ASSERT(a_sel_wrap, pop |=> (sel == 2'd0), "token index not rewound after bundle")

endmodule

// ===== design/c_subset_lexer_unit.sv =====
// top level: streaming lexer, front end, bundle queue and token back end
// tokens of an accepted byte are written to the bundle queue and output from its head
// throughput: one byte per cycle while each byte yields at most one token and
//   the token output is ready; a byte's tokens (up to 3) leave one per handshake
// the two-entry bundle queue lets input run on while output is stalled
// reset (synchronous, rst high) returns the lexer to idle at offset 0
module c_subset_lexer_unit import clx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  clx_byte_if.sink  bytes,
  clx_tok_if.source tokens
);

  logic    q_full, q_empty, push, pop;
  bundle_t push_data, head;

  clx_front u_front (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .q_full (q_full),
    .push   (push),
    .bundle (push_data)
  );

  clx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  clx_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .head   (head),
    .pop    (pop),
    .tokens (tokens)
  );

endmodule
